// ===== rtl/bsmm_pkg.sv =====
// ============================================================================
// bsmm_pkg: shared types and constants of the sort block
// Holds the store capacity, derived widths and the store control bundle.
// ============================================================================
package bsmm_pkg;

   localparam int SET_CAPACITY = 8;
   localparam int VALUE_W      = 16;
   localparam int POS_W        = 6;
   localparam int CNT_W        = $clog2(SET_CAPACITY + 1);
   localparam int IDX_W        = $clog2(SET_CAPACITY);

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [CNT_W-1:0]          count_type;
   typedef logic [IDX_W-1:0]          index_type;

   // Store control: optional shift toward the head plus one write port.
   typedef struct packed {
      logic      shift;
      logic      wr_en;
      index_type wr_idx;
      value_type wr_data;
   } store_ctrl_type;

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_SORT = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

endpackage

// ===== rtl/bsmm_cmp_unit.sv =====
// ============================================================================
// bsmm_cmp_unit: compare and exchange unit
// Orders two signed values; swaps only when the first is strictly greater.
// ============================================================================
module bsmm_cmp_unit (
   input  bsmm_pkg::value_type a_value,
   input  bsmm_pkg::value_type b_value,
   output bsmm_pkg::value_type lo_value,
   output bsmm_pkg::value_type hi_value
);
   import bsmm_pkg::*;

   logic swap;

   assign swap     = (a_value > b_value);
   assign lo_value = swap ? b_value : a_value;
   assign hi_value = swap ? a_value : b_value;

endmodule

// ===== rtl/bsmm_store.sv =====
// ============================================================================
// bsmm_store: value store as a shift line
// Entries shift toward the head; one entry can be written per cycle.
// ============================================================================
module bsmm_store (
   input  logic                     clock,
   input  bsmm_pkg::store_ctrl_type ctrl,
   output bsmm_pkg::value_type      head_value
);
   import bsmm_pkg::*;

   value_type q_ff [SET_CAPACITY];
   value_type q_in [SET_CAPACITY];

   always_comb begin
      for (int k = 0; k < SET_CAPACITY; k++) begin
         if (ctrl.shift && (k < SET_CAPACITY - 1)) begin
            q_in[k] = q_ff[k + 1];
         end else begin
            q_in[k] = q_ff[k];
         end
         if (ctrl.wr_en && (ctrl.wr_idx == IDX_W'(k))) begin
            q_in[k] = ctrl.wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SET_CAPACITY; k++) begin
         q_ff[k] <= q_in[k];
      end
   end

   assign head_value = q_ff[0];

endmodule

// ===== rtl/bubble_sort_min_max_top.sv =====
// ============================================================================
// bubble_sort_min_max_top: load, bubble sort and emit a set of values
// Collects signed values into a shift-line store, sorts them with exchange
// passes through one shared compare unit, then emits them in ascending order.
// ============================================================================
//
//  Channel | Direction | Handshake            | Beat carries
//  --------+-----------+----------------------+-------------------------------
//  req     | in        | req_valid/req_ready  | sample_value, end_of_set
//  rsp     | out       | rsp_valid/rsp_ready  | sorted_value, position, min,
//          |           |                      | max, final_result, overflowed
//
// Loading takes one cycle per req beat. After the closing beat the sort runs
// n-1 passes over the n stored values (a lone value goes straight to emit);
// every pass goes through the single compare unit one pair per cycle.
// Results then leave at one rsp beat per cycle while rsp_ready stays high.
// Reset clears the sequencer, the count and the overflow flag; the store
// itself is not cleared. req_ready is low during sort and emit, and the
// output register lets the next set start loading while the last result waits.
// ============================================================================
module bubble_sort_min_max_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  bsmm_pkg::value_type       req_sample_value,
   input  logic                      req_end_of_set,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bsmm_pkg::value_type       rsp_sorted_value,
   output logic [bsmm_pkg::POS_W-1:0] rsp_position,
   output bsmm_pkg::value_type       rsp_set_minimum,
   output bsmm_pkg::value_type       rsp_set_maximum,
   output logic                      rsp_final_result,
   output logic                      rsp_overflowed
);
   import bsmm_pkg::*;

   // Sequencer and bookkeeping registers.
   state_type state_ff, state_in;
   count_type count_ff, count_in;
   logic      ovf_ff, ovf_in;
   count_type pass_ff, pass_in;
   count_type step_ff, step_in;
   count_type pos_ff, pos_in;
   value_type carry_ff, carry_in;
   value_type min_ff, min_in;
   value_type max_ff, max_in;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   value_type        rsp_value_ff, rsp_value_in;
   logic [POS_W-1:0] rsp_pos_ff, rsp_pos_in;
   value_type        rsp_min_ff, rsp_min_in;
   value_type        rsp_max_ff, rsp_max_in;
   logic             rsp_final_ff, rsp_final_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   store_ctrl_type store_ctrl;
   value_type      head_value;
   value_type      cmp_lo;
   value_type      cmp_hi;
   logic           req_fire;
   logic           rsp_free;
   logic           emit_last;
   index_type      tail_idx;

   bsmm_store u_store (
      .clock      (clock),
      .ctrl       (store_ctrl),
      .head_value (head_value)
   );

   // The carry holds the running larger value of the current pass.
   bsmm_cmp_unit u_cmp (
      .a_value  (carry_ff),
      .b_value  (head_value),
      .lo_value (cmp_lo),
      .hi_value (cmp_hi)
   );

   assign req_ready = (state_ff == ST_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign emit_last = ((pos_ff + 1'b1) == count_ff);
   assign tail_idx  = IDX_W'(count_ff - 1'b1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      pass_in      = pass_ff;
      step_in      = step_ff;
      pos_in       = pos_ff;
      carry_in     = carry_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_final_in = rsp_final_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      store_ctrl.shift   = 1'b0;
      store_ctrl.wr_en   = 1'b0;
      store_ctrl.wr_idx  = count_ff[IDX_W-1:0];
      store_ctrl.wr_data = req_sample_value;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (count_ff < CNT_W'(SET_CAPACITY)) begin
                  store_ctrl.wr_en = 1'b1;
                  count_in         = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_end_of_set) begin
                  state_in = ST_SORT;
                  pass_in  = '0;
                  step_in  = '0;
               end
            end
         end
         ST_SORT: begin
            if (count_ff == CNT_W'(1)) begin
               // A single value is already in order and is its own maximum.
               max_in   = head_value;
               pos_in   = '0;
               state_in = ST_EMIT;
            end else begin
               // Every step pulls the head; all steps but the first refill the tail of the set.
               store_ctrl.shift  = 1'b1;
               store_ctrl.wr_idx = tail_idx;
               if (step_ff == '0) begin
                  carry_in = head_value;
                  step_in  = step_ff + 1'b1;
               end else if (step_ff < count_ff) begin
                  store_ctrl.wr_en   = 1'b1;
                  store_ctrl.wr_data = cmp_lo;
                  carry_in           = cmp_hi;
                  step_in            = step_ff + 1'b1;
               end else begin
                  // The carry is the largest value of this pass.
                  store_ctrl.wr_en   = 1'b1;
                  store_ctrl.wr_data = carry_ff;
                  step_in            = '0;
                  if ((pass_ff + 2'd2) == count_ff) begin
                     max_in   = carry_ff;
                     pos_in   = '0;
                     state_in = ST_EMIT;
                  end else begin
                     pass_in = pass_ff + 1'b1;
                  end
               end
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               store_ctrl.shift = 1'b1;
               rsp_valid_in     = 1'b1;
               rsp_value_in     = head_value;
               rsp_pos_in       = POS_W'(pos_ff);
               rsp_max_in       = max_ff;
               rsp_final_in     = emit_last;
               rsp_ovf_in       = ovf_ff;
               if (pos_ff == '0) begin
                  // The head of the sorted set is the minimum.
                  min_in     = head_value;
                  rsp_min_in = head_value;
               end else begin
                  rsp_min_in = min_ff;
               end
               pos_in = pos_ff + 1'b1;
               if (emit_last) begin
                  state_in = ST_LOAD;
                  count_in = '0;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         pass_ff      <= '0;
         step_ff      <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         pass_ff      <= pass_in;
         step_ff      <= step_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff     <= carry_in;
      min_ff       <= min_in;
      max_ff       <= max_in;
      rsp_value_ff <= rsp_value_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_min_ff   <= rsp_min_in;
      rsp_max_ff   <= rsp_max_in;
      rsp_final_ff <= rsp_final_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_set_minimum  = rsp_min_ff;
   assign rsp_set_maximum  = rsp_max_ff;
   assign rsp_final_result = rsp_final_ff;
   assign rsp_overflowed   = rsp_ovf_ff;

endmodule
